[sv/aes_pkg.sv]
// ----------------------------------------------------------------------------
// aes_pkg
// Shared constants and GF(2^8) helper functions for the AES-128 encryptor.
// ----------------------------------------------------------------------------
package aes_pkg;

  localparam int unsigned NumRounds = 10;
  localparam int unsigned KeyWidth  = 128;

  localparam logic [0:0] RegKeyUpper = 1'b0;
  localparam logic [0:0] RegKeyLower = 1'b1;

  typedef logic [KeyWidth-1:0] block_t;

  function automatic logic [7:0] sbox(input logic [7:0] x);
    logic [7:0] s;
    unique case (x)
      8'h00: s=8'h63; 8'h01: s=8'h7c; 8'h02: s=8'h77; 8'h03: s=8'h7b;
      8'h04: s=8'hf2; 8'h05: s=8'h6b; 8'h06: s=8'h6f; 8'h07: s=8'hc5;
      8'h08: s=8'h30; 8'h09: s=8'h01; 8'h0a: s=8'h67; 8'h0b: s=8'h2b;
      8'h0c: s=8'hfe; 8'h0d: s=8'hd7; 8'h0e: s=8'hab; 8'h0f: s=8'h76;
      8'h10: s=8'hca; 8'h11: s=8'h82; 8'h12: s=8'hc9; 8'h13: s=8'h7d;
      8'h14: s=8'hfa; 8'h15: s=8'h59; 8'h16: s=8'h47; 8'h17: s=8'hf0;
      8'h18: s=8'had; 8'h19: s=8'hd4; 8'h1a: s=8'ha2; 8'h1b: s=8'haf;
      8'h1c: s=8'h9c; 8'h1d: s=8'ha4; 8'h1e: s=8'h72; 8'h1f: s=8'hc0;
      8'h20: s=8'hb7; 8'h21: s=8'hfd; 8'h22: s=8'h93; 8'h23: s=8'h26;
      8'h24: s=8'h36; 8'h25: s=8'h3f; 8'h26: s=8'hf7; 8'h27: s=8'hcc;
      8'h28: s=8'h34; 8'h29: s=8'ha5; 8'h2a: s=8'he5; 8'h2b: s=8'hf1;
      8'h2c: s=8'h71; 8'h2d: s=8'hd8; 8'h2e: s=8'h31; 8'h2f: s=8'h15;
      8'h30: s=8'h04; 8'h31: s=8'hc7; 8'h32: s=8'h23; 8'h33: s=8'hc3;
      8'h34: s=8'h18; 8'h35: s=8'h96; 8'h36: s=8'h05; 8'h37: s=8'h9a;
      8'h38: s=8'h07; 8'h39: s=8'h12; 8'h3a: s=8'h80; 8'h3b: s=8'he2;
      8'h3c: s=8'heb; 8'h3d: s=8'h27; 8'h3e: s=8'hb2; 8'h3f: s=8'h75;
      8'h40: s=8'h09; 8'h41: s=8'h83; 8'h42: s=8'h2c; 8'h43: s=8'h1a;
      8'h44: s=8'h1b; 8'h45: s=8'h6e; 8'h46: s=8'h5a; 8'h47: s=8'ha0;
      8'h48: s=8'h52; 8'h49: s=8'h3b; 8'h4a: s=8'hd6; 8'h4b: s=8'hb3;
      8'h4c: s=8'h29; 8'h4d: s=8'he3; 8'h4e: s=8'h2f; 8'h4f: s=8'h84;
      8'h50: s=8'h53; 8'h51: s=8'hd1; 8'h52: s=8'h00; 8'h53: s=8'hed;
      8'h54: s=8'h20; 8'h55: s=8'hfc; 8'h56: s=8'hb1; 8'h57: s=8'h5b;
      8'h58: s=8'h6a; 8'h59: s=8'hcb; 8'h5a: s=8'hbe; 8'h5b: s=8'h39;
      8'h5c: s=8'h4a; 8'h5d: s=8'h4c; 8'h5e: s=8'h58; 8'h5f: s=8'hcf;
      8'h60: s=8'hd0; 8'h61: s=8'hef; 8'h62: s=8'haa; 8'h63: s=8'hfb;
      8'h64: s=8'h43; 8'h65: s=8'h4d; 8'h66: s=8'h33; 8'h67: s=8'h85;
      8'h68: s=8'h45; 8'h69: s=8'hf9; 8'h6a: s=8'h02; 8'h6b: s=8'h7f;
      8'h6c: s=8'h50; 8'h6d: s=8'h3c; 8'h6e: s=8'h9f; 8'h6f: s=8'ha8;
      8'h70: s=8'h51; 8'h71: s=8'ha3; 8'h72: s=8'h40; 8'h73: s=8'h8f;
      8'h74: s=8'h92; 8'h75: s=8'h9d; 8'h76: s=8'h38; 8'h77: s=8'hf5;
      8'h78: s=8'hbc; 8'h79: s=8'hb6; 8'h7a: s=8'hda; 8'h7b: s=8'h21;
      8'h7c: s=8'h10; 8'h7d: s=8'hff; 8'h7e: s=8'hf3; 8'h7f: s=8'hd2;
      8'h80: s=8'hcd; 8'h81: s=8'h0c; 8'h82: s=8'h13; 8'h83: s=8'hec;
      8'h84: s=8'h5f; 8'h85: s=8'h97; 8'h86: s=8'h44; 8'h87: s=8'h17;
      8'h88: s=8'hc4; 8'h89: s=8'ha7; 8'h8a: s=8'h7e; 8'h8b: s=8'h3d;
      8'h8c: s=8'h64; 8'h8d: s=8'h5d; 8'h8e: s=8'h19; 8'h8f: s=8'h73;
      8'h90: s=8'h60; 8'h91: s=8'h81; 8'h92: s=8'h4f; 8'h93: s=8'hdc;
      8'h94: s=8'h22; 8'h95: s=8'h2a; 8'h96: s=8'h90; 8'h97: s=8'h88;
      8'h98: s=8'h46; 8'h99: s=8'hee; 8'h9a: s=8'hb8; 8'h9b: s=8'h14;
      8'h9c: s=8'hde; 8'h9d: s=8'h5e; 8'h9e: s=8'h0b; 8'h9f: s=8'hdb;
      8'ha0: s=8'he0; 8'ha1: s=8'h32; 8'ha2: s=8'h3a; 8'ha3: s=8'h0a;
      8'ha4: s=8'h49; 8'ha5: s=8'h06; 8'ha6: s=8'h24; 8'ha7: s=8'h5c;
      8'ha8: s=8'hc2; 8'ha9: s=8'hd3; 8'haa: s=8'hac; 8'hab: s=8'h62;
      8'hac: s=8'h91; 8'had: s=8'h95; 8'hae: s=8'he4; 8'haf: s=8'h79;
      8'hb0: s=8'he7; 8'hb1: s=8'hc8; 8'hb2: s=8'h37; 8'hb3: s=8'h6d;
      8'hb4: s=8'h8d; 8'hb5: s=8'hd5; 8'hb6: s=8'h4e; 8'hb7: s=8'ha9;
      8'hb8: s=8'h6c; 8'hb9: s=8'h56; 8'hba: s=8'hf4; 8'hbb: s=8'hea;
      8'hbc: s=8'h65; 8'hbd: s=8'h7a; 8'hbe: s=8'hae; 8'hbf: s=8'h08;
      8'hc0: s=8'hba; 8'hc1: s=8'h78; 8'hc2: s=8'h25; 8'hc3: s=8'h2e;
      8'hc4: s=8'h1c; 8'hc5: s=8'ha6; 8'hc6: s=8'hb4; 8'hc7: s=8'hc6;
      8'hc8: s=8'he8; 8'hc9: s=8'hdd; 8'hca: s=8'h74; 8'hcb: s=8'h1f;
      8'hcc: s=8'h4b; 8'hcd: s=8'hbd; 8'hce: s=8'h8b; 8'hcf: s=8'h8a;
      8'hd0: s=8'h70; 8'hd1: s=8'h3e; 8'hd2: s=8'hb5; 8'hd3: s=8'h66;
      8'hd4: s=8'h48; 8'hd5: s=8'h03; 8'hd6: s=8'hf6; 8'hd7: s=8'h0e;
      8'hd8: s=8'h61; 8'hd9: s=8'h35; 8'hda: s=8'h57; 8'hdb: s=8'hb9;
      8'hdc: s=8'h86; 8'hdd: s=8'hc1; 8'hde: s=8'h1d; 8'hdf: s=8'h9e;
      8'he0: s=8'he1; 8'he1: s=8'hf8; 8'he2: s=8'h98; 8'he3: s=8'h11;
      8'he4: s=8'h69; 8'he5: s=8'hd9; 8'he6: s=8'h8e; 8'he7: s=8'h94;
      8'he8: s=8'h9b; 8'he9: s=8'h1e; 8'hea: s=8'h87; 8'heb: s=8'he9;
      8'hec: s=8'hce; 8'hed: s=8'h55; 8'hee: s=8'h28; 8'hef: s=8'hdf;
      8'hf0: s=8'h8c; 8'hf1: s=8'ha1; 8'hf2: s=8'h89; 8'hf3: s=8'h0d;
      8'hf4: s=8'hbf; 8'hf5: s=8'he6; 8'hf6: s=8'h42; 8'hf7: s=8'h68;
      8'hf8: s=8'h41; 8'hf9: s=8'h99; 8'hfa: s=8'h2d; 8'hfb: s=8'h0f;
      8'hfc: s=8'hb0; 8'hfd: s=8'h54; 8'hfe: s=8'hbb; 8'hff: s=8'h16;
      default: s = 8'h00;
    endcase
    return s;
  endfunction

  function automatic logic [7:0] rcon(input logic [3:0] r);
    logic [7:0] v;
    unique case (r)
      4'd1: v = 8'h01; 4'd2: v = 8'h02; 4'd3: v = 8'h04; 4'd4: v = 8'h08;
      4'd5: v = 8'h10; 4'd6: v = 8'h20; 4'd7: v = 8'h40; 4'd8: v = 8'h80;
      4'd9: v = 8'h1b; 4'd10: v = 8'h36;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  // byte i of the state sits at bits [127-8i -: 8]
  function automatic block_t sub_shift(input block_t st);
    block_t o;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        o[127 - 8*(4*c + r) -: 8] = sbox(st[127 - 8*(4*((c + r) % 4) + r) -: 8]);
      end
    end
    return o;
  endfunction

  function automatic block_t mix(input block_t st);
    block_t o;
    logic [7:0] a0, a1, a2, a3, al;
    for (int c = 0; c < 4; c++) begin
      a0 = st[127 - 32*c -: 8];
      a1 = st[119 - 32*c -: 8];
      a2 = st[111 - 32*c -: 8];
      a3 = st[103 - 32*c -: 8];
      al = a0 ^ a1 ^ a2 ^ a3;
      o[127 - 32*c -: 8] = a0 ^ al ^ xtime(a0 ^ a1);
      o[119 - 32*c -: 8] = a1 ^ al ^ xtime(a1 ^ a2);
      o[111 - 32*c -: 8] = a2 ^ al ^ xtime(a2 ^ a3);
      o[103 - 32*c -: 8] = a3 ^ al ^ xtime(a3 ^ a0);
    end
    return o;
  endfunction

  function automatic block_t next_key(input block_t k, input logic [3:0] r);
    block_t o;
    logic [31:0] t;
    t = {sbox(k[23:16]) ^ rcon(r), sbox(k[15:8]), sbox(k[7:0]), sbox(k[31:24])};
    o[127:96] = k[127:96] ^ t;
    o[95:64]  = k[95:64] ^ o[127:96];
    o[63:32]  = k[63:32] ^ o[95:64];
    o[31:0]   = k[31:0] ^ o[63:32];
    return o;
  endfunction

endpackage

[sv/aes128_block_encrypt_top.sv]
// ----------------------------------------------------------------------------
// aes128_block_encrypt_top
// AES-128 ECB encryptor, fully unrolled pipeline, one block per cycle.
// ----------------------------------------------------------------------------
// Usage:
//   Write the key through cfg_we/cfg_index/cfg_data (index 0 upper, 1 lower)
//   while the pipe is empty. Present a word on plain_upper/plain_lower with
//   start high; busy is always low, so a word is taken every cycle.
//   Pipeline: one input stage for the initial key add, then one register
//   stage per round. Throughput: one word per cycle, set by the ten round
//   stages each carrying its own key step.
//   The result shows on cipher_upper/cipher_lower for one cycle with done
//   high; the receiver cannot stall.
//   Reset clears the key registers to zero and all stage valid bits.
// ----------------------------------------------------------------------------
module aes128_block_encrypt_top import aes_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] plain_upper,
  input  logic [63:0] plain_lower,
  output logic        done,
  output logic [63:0] cipher_upper,
  output logic [63:0] cipher_lower,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  logic [63:0] key_upper;
  logic [63:0] key_lower;

  logic   vld [NumRounds+1];
  block_t st  [NumRounds+1];
  block_t rk  [NumRounds+1];

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_upper <= '0;
      key_lower <= '0;
      vld[0]    <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          RegKeyUpper: key_upper <= cfg_data;
          RegKeyLower: key_lower <= cfg_data;
          default: ;
        endcase
      end
      vld[0] <= start;
    end
    st[0] <= {plain_upper, plain_lower} ^ {key_upper, key_lower};
    rk[0] <= {key_upper, key_lower};
  end

  for (genvar g = 0; g < NumRounds; g++) begin : g_round
    aes_round u_round (
      .clk       (clk),
      .rst       (rst),
      .round     (4'(g + 1)),
      .in_valid  (vld[g]),
      .in_state  (st[g]),
      .in_key    (rk[g]),
      .out_valid (vld[g+1]),
      .out_state (st[g+1]),
      .out_key   (rk[g+1])
    );
  end

  assign done         = vld[NumRounds];
  assign cipher_upper = st[NumRounds][127:64];
  assign cipher_lower = st[NumRounds][63:0];

endmodule

[sv/aes_round.sv]
// ----------------------------------------------------------------------------
// aes_round
// One registered cipher round plus the matching key-schedule step.
// ----------------------------------------------------------------------------
module aes_round import aes_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic [3:0] round,
  input  logic       in_valid,
  input  block_t     in_state,
  input  block_t     in_key,
  output logic       out_valid,
  output block_t     out_state,
  output block_t     out_key
);

  block_t ss;
  block_t nk;

  always_comb begin
    ss = sub_shift(in_state);
    nk = next_key(in_key, round);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
    out_key <= nk;
    if (round == 4'(NumRounds)) begin
      out_state <= ss ^ nk;
    end else begin
      out_state <= mix(ss) ^ nk;
    end
  end

endmodule

[tb/sv/tb_aes128_block_encrypt_top.sv]
// ----------------------------------------------------------------------------
// tb_aes128_block_encrypt_top
// Self-checking bench for the AES-128 ECB encryptor. Words go in with bursty
// start timing; an in-bench cipher predicts each ciphertext, and every done
// strobe is compared in order against the oldest prediction. Keys are changed
// only with the pipe empty.
// ----------------------------------------------------------------------------
module tb_aes128_block_encrypt_top import aes_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PipeDepth  = 11;
  localparam int CycleLimit = 200000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [63:0] plain_upper = '0;
  logic [63:0] plain_lower = '0;
  logic        done;
  logic [63:0] cipher_upper;
  logic [63:0] cipher_lower;
  logic        cfg_we = 1'b0;
  logic [0:0]  cfg_index = RegKeyUpper;
  logic [63:0] cfg_data = '0;

  logic [127:0] cipher_key = '0;
  logic [127:0] cipher_fifo[$];
  int           err_cnt = 0;
  int           word_cnt = 0;
  int           key_cnt = 0;
  int           cycle_cnt = 0;

  aes128_block_encrypt_top DUT (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  byte unsigned sbox_lut[256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic byte unsigned gf_dbl(byte unsigned x);
    return byte'((x << 1) ^ (x[7] ? 8'h1b : 8'h00));
  endfunction

  // byte array form: index 0 is the top byte
  function automatic logic [127:0] encipher_block(logic [127:0] key, logic [127:0] pt);
    byte unsigned rk[176];
    byte unsigned st[16];
    byte unsigned nx[16];
    byte unsigned w[4];
    byte unsigned rc;
    byte unsigned hold;
    byte unsigned a0, a1, a2, a3, sum;
    logic [127:0] ct;
    rc = 8'h01;
    for (int i = 0; i < 16; i++) begin
      rk[i] = key[127-8*i -: 8];
      st[i] = pt[127-8*i -: 8] ^ key[127-8*i -: 8];
    end
    for (int i = 16; i < 176; i += 4) begin
      for (int j = 0; j < 4; j++) w[j] = rk[i-4+j];
      if (i % 16 == 0) begin
        hold = w[0];
        w[0] = sbox_lut[w[1]] ^ rc;
        w[1] = sbox_lut[w[2]];
        w[2] = sbox_lut[w[3]];
        w[3] = sbox_lut[hold];
        rc = gf_dbl(rc);
      end
      for (int j = 0; j < 4; j++) rk[i+j] = rk[i-16+j] ^ w[j];
    end
    for (int rnd = 1; rnd <= 10; rnd++) begin
      for (int c = 0; c < 4; c++)
        for (int r = 0; r < 4; r++) nx[4*c+r] = sbox_lut[st[4*((c+r)%4)+r]];
      if (rnd < 10) begin
        for (int c = 0; c < 4; c++) begin
          a0 = nx[4*c]; a1 = nx[4*c+1]; a2 = nx[4*c+2]; a3 = nx[4*c+3];
          sum = a0 ^ a1 ^ a2 ^ a3;
          nx[4*c]   = a0 ^ sum ^ gf_dbl(a0 ^ a1);
          nx[4*c+1] = a1 ^ sum ^ gf_dbl(a1 ^ a2);
          nx[4*c+2] = a2 ^ sum ^ gf_dbl(a2 ^ a3);
          nx[4*c+3] = a3 ^ sum ^ gf_dbl(a3 ^ a0);
        end
      end
      for (int i = 0; i < 16; i++) st[i] = nx[i] ^ rk[16*rnd+i];
    end
    for (int i = 0; i < 16; i++) ct[127-8*i -: 8] = st[i];
    return ct;
  endfunction

  // checker: done cannot be held off, sample every rising edge
  always @(posedge clk) begin
    logic [127:0] exp_ct;
    cycle_cnt <= cycle_cnt + 1;
    if (!rst && done === 1'b1) begin
      if (cipher_fifo.size() == 0) begin
        $display("%0t: unexpected word %h %h", $time, cipher_upper, cipher_lower);
        err_cnt++;
      end else begin
        exp_ct = cipher_fifo.pop_front();
        if (cipher_upper !== exp_ct[127:64]) begin
          $display("%0t: cipher_upper exp %h got %h", $time, exp_ct[127:64], cipher_upper);
          err_cnt++;
        end
        if (cipher_lower !== exp_ct[63:0]) begin
          $display("%0t: cipher_lower exp %h got %h", $time, exp_ct[63:0], cipher_lower);
          err_cnt++;
        end
      end
    end
    if (cycle_cnt > CycleLimit) begin
      $display("timeout at cycle %0d", cycle_cnt);
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic write_reg(logic [0:0] idx, logic [63:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == RegKeyUpper) cipher_key[127:64] = val;
    else cipher_key[63:0] = val;
    key_cnt++;
  endtask

  task automatic load_key(logic [127:0] key);
    write_reg(RegKeyUpper, key[127:64]);
    write_reg(RegKeyLower, key[63:0]);
  endtask

  task automatic wait_drain();
    while (cipher_fifo.size() != 0) @(posedge clk);
    repeat (PipeDepth + 2) @(posedge clk);
  endtask

  // start stays high across back-to-back words; dropped only by the caller
  task automatic send_word(logic [63:0] hi, logic [63:0] lo);
    @(negedge clk);
    start       <= 1'b1;
    plain_upper <= hi;
    plain_lower <= lo;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    cipher_fifo.push_back(encipher_block(cipher_key, {hi, lo}));
    word_cnt++;
  endtask

  task automatic idle(int n);
    if (n > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  task automatic test_known_vector();
    // standard cipher vector plus the all-zero key case
    send_word(64'h0011223344556677, 64'h8899aabbccddeeff);
    send_word('0, '0);
    idle(1);
    wait_drain();
    load_key(128'h000102030405060708090a0b0c0d0e0f);
    send_word(64'h0011223344556677, 64'h8899aabbccddeeff);
    idle(1);
    wait_drain();
  endtask

  task automatic test_extremes();
    load_key({128{1'b1}});
    send_word('0, '0);
    send_word('1, '1);
    send_word(64'h8000000000000000, 64'h0000000000000001);
    send_word(64'h5555555555555555, 64'haaaaaaaaaaaaaaaa);
    idle(1);
    wait_drain();
    load_key(128'h2b7e151628aed2a6abf7158809cf4f3c);
    send_word(64'h3243f6a8885a308d, 64'h313198a2e0370734);
    send_word(64'haaaaaaaaaaaaaaaa, 64'h5555555555555555);
    idle(1);
    wait_drain();
    // only the upper half changes; lower half must persist
    write_reg(RegKeyUpper, '0);
    send_word('1, '0);
    idle(1);
    wait_drain();
  endtask

  task automatic test_random_stream(int n_words);
    int left;
    int burst;
    left = n_words;
    while (left > 0) begin
      if ($urandom_range(0, 7) == 0) begin
        idle(1);
        wait_drain();
        if ($urandom_range(0, 1)) load_key({rand64(), rand64()});
        else write_reg(logic'($urandom_range(0, 1)), rand64());
      end
      burst = $urandom_range(1, 40);
      for (int i = 0; i < burst && left > 0; i++, left--) begin
        send_word(rand64(), rand64());
        if ($urandom_range(0, 3) == 0) idle($urandom_range(1, 6));
      end
      idle($urandom_range(0, 20));
    end
    idle(1);
    wait_drain();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_known_vector();
    test_extremes();
    test_random_stream(1000);
    $display("Sent %0d words under %0d key register writes, bursts and gaps mixed.",
             word_cnt, key_cnt);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[aes128_block_encrypt_top.f]
sv/aes_pkg.sv
sv/aes_round.sv
sv/aes128_block_encrypt_top.sv
tb/sv/tb_aes128_block_encrypt_top.sv
